// ----- rtl/cfm_pkg.sv -----
// Package for the command framer with message mailbox.
// Holds the request, result and command codes used by the top-level RTL file; no dependencies.
package cfm_pkg;

    // Request types on the input channel.
    localparam logic [1:0] REQ_HOST_WRITE = 2'd0;
    localparam logic [1:0] REQ_HOST_READ  = 2'd1;
    localparam logic [1:0] REQ_NET_BYTE   = 2'd2;

    // Result kinds on the output channel.
    localparam logic [1:0] KIND_READ      = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD   = 2'd1;
    localparam logic [1:0] KIND_EMPTY_MSG = 2'd2;

    // Special command codes (low nibble of a special header).
    localparam logic [3:0] SPC_RESET = 4'h0;
    localparam logic [3:0] SPC_POLL  = 4'h9;
    localparam logic [3:0] SPC_SENT  = 4'hA;

    localparam logic [7:0] RESET_REPLY = 8'hA5;
    localparam logic [3:0] CONN_META   = 4'hF;

endpackage

// ----- rtl/command_framer_with_message_mailbox.sv -----
// Top level of the command framer with message mailbox.
// Depends on cfm_pkg and cfm_store.
//
// Usage. Every transaction on the input channel (in_valid/in_ready) is either a
// host write of a command byte, a host read of the data register, or one byte of
// a received network datagram. Host writes are gathered into commands framed by
// their header byte; message command payload bytes for an open connection leave
// on the output channel (out_valid/out_ready) as they arrive, and a host read
// returns the data register there. Received datagrams are stored in a queue of
// MSG_SLOTS slots of MSG_BYTES bytes in a memory with one write, one read port.
// Timing. A NEXT command that pops a stored byte first addresses the message
// memory, then captures its registered read data in the S_NEXT state, during
// which the input is not ready. Results appear in the output register on the
// cycle after acceptance.
// Stalls. A result waits in the output register; a new transaction is accepted
// while it waits only if that cycle also hands the waiting result over, so the
// output register never overflows.
// Reset. rst_n clears all control state, the queue is empty and no command is
// pending; the memory contents are undefined until written and need no clearing.
module command_framer_with_message_mailbox #(
    parameter int MSG_SLOTS = 16,
    parameter int MSG_BYTES = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [14:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [7:0]  value,
    input  logic        last,
    input  logic        empty_datagram,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  data,
    output logic [3:0]  connection,
    output logic        end_of_message
);

    localparam int SW    = $clog2(MSG_SLOTS);
    localparam int CW    = $clog2(MSG_SLOTS + 1);
    localparam int PW    = $clog2(MSG_BYTES + 1);
    localparam int DEPTH = MSG_SLOTS * MSG_BYTES;
    localparam int AW    = $clog2(DEPTH);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_NEXT = 1'b1;

    logic          state_reg, state_next;
    logic [14:0]   open_reg;
    logic [15:0]   open_ext;
    logic [7:0]    data_reg, data_next;
    logic [7:0]    hdr_reg, hdr_next;
    logic [7:0]    len_cmd_reg, len_cmd_next;
    logic [8:0]    cnt_reg, cnt_next;
    logic [SW-1:0] head_reg, head_next;
    logic [SW-1:0] tail_reg, tail_next;
    logic [CW-1:0] qcnt_reg, qcnt_next;
    logic [PW-1:0] rpos_reg, rpos_next;
    logic [PW-1:0] fpos_reg, fpos_next;
    logic          rx_act_reg, rx_act_next;
    logic          rx_drop_reg, rx_drop_next;

    // Lengths of the queued messages; written at the tail, read at the head.
    logic [PW-1:0] msg_len_reg [MSG_SLOTS];
    logic          len_we;
    logic [PW-1:0] len_wdata;

    logic          ovalid_reg, ovalid_next;
    logic [1:0]    kind_reg, kind_next;
    logic [7:0]    odata_reg, odata_next;
    logic [3:0]    conn_reg, conn_next;
    logic          eom_reg, eom_next;

    logic          accept;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_rdata;

    function automatic logic [SW-1:0] slot_next(input logic [SW-1:0] s);
        slot_next = (s == SW'(MSG_SLOTS - 1)) ? '0 : s + 1'b1;
    endfunction

    assign in_ready = (state_reg == S_IDLE) && (!ovalid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    // The metadata connection maps onto the top bit, which is never open.
    assign open_ext = {1'b0, open_reg};

    cfm_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (value),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        logic [7:0]    hdr;
        logic [8:0]    cnt;
        logic          long_msg;
        logic [3:0]    conn;
        logic [8:0]    len;
        logic [8:0]    first;
        logic          complete;
        logic          open;
        logic          drop;
        logic [PW-1:0] fp;
        logic [PW-1:0] head_len;

        state_next   = state_reg;
        data_next    = data_reg;
        hdr_next     = hdr_reg;
        len_cmd_next = len_cmd_reg;
        cnt_next     = cnt_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        qcnt_next    = qcnt_reg;
        rpos_next    = rpos_reg;
        fpos_next    = fpos_reg;
        rx_act_next  = rx_act_reg;
        rx_drop_next = rx_drop_reg;
        len_we       = 1'b0;
        len_wdata    = '0;
        ovalid_next  = ovalid_reg && !out_ready;
        kind_next    = kind_reg;
        odata_next   = odata_reg;
        conn_next    = conn_reg;
        eom_next     = eom_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_waddr    = '0;
        mem_raddr    = AW'(head_reg) * AW'(MSG_BYTES) + AW'(rpos_reg);

        head_len  = msg_len_reg[head_reg];
        hdr       = (cnt_reg == 9'd0) ? value : hdr_reg;
        cnt       = cnt_reg + 9'd1;
        long_msg  = hdr[5];
        conn      = long_msg ? hdr[3:0] : 4'd0;
        if (long_msg)
        begin
            len = (cnt == 9'd2) ? {1'b0, value} : {1'b0, len_cmd_reg};
        end
        else
        begin
            len = {5'd0, hdr[3:0]};
        end
        first    = long_msg ? 9'd3 : 9'd2;
        complete = 1'b0;
        open     = (conn != cfm_pkg::CONN_META) && open_ext[conn];
        drop     = rx_act_reg ? rx_drop_reg : (qcnt_reg >= CW'(MSG_SLOTS));
        fp       = rx_act_reg ? fpos_reg : '0;

        if (state_reg == S_NEXT)
        begin
            // Registered read data of the popped byte arrives now.
            data_next  = mem_rdata;
            rpos_next  = rpos_reg + 1'b1;
            state_next = S_IDLE;
        end
        else if (accept)
        begin
            case (req_type)
                cfm_pkg::REQ_HOST_WRITE:
                begin
                    data_next = value;
                    hdr_next  = hdr;
                    if (cnt_reg == 9'd0)
                    begin
                        len_cmd_next = 8'd0;
                    end
                    if (hdr[7:4] == 4'd0)
                    begin
                        // NEXT: pop one byte of the front message if any remain.
                        complete = 1'b1;
                        if (qcnt_reg != '0 && rpos_reg < head_len
                            && rpos_reg < PW'(MSG_BYTES))
                        begin
                            mem_re     = 1'b1;
                            state_next = S_NEXT;
                        end
                    end
                    else if (hdr[6])
                    begin
                        complete = (cnt >= 9'd2);
                    end
                    else if (hdr[4])
                    begin
                        complete = 1'b1;
                        case (hdr[3:0])
                            cfm_pkg::SPC_RESET: data_next = cfm_pkg::RESET_REPLY;
                            cfm_pkg::SPC_SENT:  data_next = 8'd0;
                            cfm_pkg::SPC_POLL:
                            begin
                                if (qcnt_reg != '0
                                    && (head_len == '0 || rpos_reg != '0))
                                begin
                                    head_next = slot_next(head_reg);
                                    qcnt_next = qcnt_reg - 1'b1;
                                    rpos_next = '0;
                                    data_next = 8'(qcnt_reg - 1'b1);
                                end
                                else
                                begin
                                    data_next = 8'(qcnt_reg);
                                end
                            end
                            default: ;
                        endcase
                    end
                    else
                    begin
                        len_cmd_next = len[7:0];
                        if (long_msg && cnt < 9'd2)
                        begin
                            complete = 1'b0;
                        end
                        else
                        begin
                            complete = (cnt >= first - 9'd1 + len);
                            if (cnt >= first && open)
                            begin
                                ovalid_next = 1'b1;
                                kind_next   = cfm_pkg::KIND_PAYLOAD;
                                odata_next  = value;
                                conn_next   = conn;
                                eom_next    = complete;
                            end
                            else if (complete && len == 9'd0 && open)
                            begin
                                ovalid_next = 1'b1;
                                kind_next   = cfm_pkg::KIND_EMPTY_MSG;
                                odata_next  = 8'd0;
                                conn_next   = conn;
                                eom_next    = 1'b1;
                            end
                        end
                    end
                    cnt_next = complete ? 9'd0 : cnt;
                end
                cfm_pkg::REQ_HOST_READ:
                begin
                    ovalid_next = 1'b1;
                    kind_next   = cfm_pkg::KIND_READ;
                    odata_next  = data_reg;
                    conn_next   = 4'd0;
                    eom_next    = 1'b0;
                end
                cfm_pkg::REQ_NET_BYTE:
                begin
                    rx_act_next  = 1'b1;
                    rx_drop_next = drop;
                    fpos_next    = fp;
                    if (!empty_datagram && fp < PW'(MSG_BYTES))
                    begin
                        mem_we    = !drop;
                        mem_waddr = AW'(tail_reg) * AW'(MSG_BYTES) + AW'(fp);
                        fpos_next = fp + 1'b1;
                    end
                    if (last || empty_datagram)
                    begin
                        if (!drop && qcnt_reg < CW'(MSG_SLOTS))
                        begin
                            len_we    = 1'b1;
                            len_wdata = fpos_next;
                            if (qcnt_reg == '0)
                            begin
                                rpos_next = '0;
                            end
                            tail_next = slot_next(tail_reg);
                            qcnt_next = qcnt_reg + 1'b1;
                        end
                        rx_act_next  = 1'b0;
                        rx_drop_next = 1'b0;
                        fpos_next    = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            msg_len_reg[tail_reg] <= len_wdata;
        end
        kind_reg  <= kind_next;
        odata_reg <= odata_next;
        conn_reg  <= conn_next;
        eom_reg   <= eom_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            open_reg    <= '0;
            data_reg    <= '0;
            hdr_reg     <= '0;
            len_cmd_reg <= '0;
            cnt_reg     <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            qcnt_reg    <= '0;
            rpos_reg    <= '0;
            fpos_reg    <= '0;
            rx_act_reg  <= 1'b0;
            rx_drop_reg <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            if (cfg_we)
            begin
                open_reg <= cfg_wdata;
            end
            data_reg    <= data_next;
            hdr_reg     <= hdr_next;
            len_cmd_reg <= len_cmd_next;
            cnt_reg     <= cnt_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            qcnt_reg    <= qcnt_next;
            rpos_reg    <= rpos_next;
            fpos_reg    <= fpos_next;
            rx_act_reg  <= rx_act_next;
            rx_drop_reg <= rx_drop_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    assign out_valid      = ovalid_reg;
    assign kind           = kind_reg;
    assign data           = odata_reg;
    assign connection     = conn_reg;
    assign end_of_message = eom_reg;

endmodule

// ----- rtl/cfm_store.sv -----
// Message byte store: a synchronous memory with one write port and one registered read port.
// Depends on nothing; instantiated by command_framer_with_message_mailbox.
module cfm_store #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
